>>> hdl/jss_pkg.sv
package jss_pkg;

    // Fixed field widths
    localparam int AXIS_W   = 10;
    localparam int DEG_W    = 8;
    localparam int ALPHA_W  = 9;
    localparam int STEP_W   = 6;
    localparam int SMOOTH_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Axis count and one-hot-free axis codes, in servo order
    localparam int AXIS_COUNT = 4;
    localparam int AXIS_IDX_W = 2;
    localparam logic [AXIS_IDX_W-1:0] AXIS_LEFT_Y  = 2'd0;
    localparam logic [AXIS_IDX_W-1:0] AXIS_RIGHT_X = 2'd1;
    localparam logic [AXIS_IDX_W-1:0] AXIS_RIGHT_Y = 2'd2;
    localparam logic [AXIS_IDX_W-1:0] AXIS_LEFT_X  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEFT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEFT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_RIGHT_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_RIGHT_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 3'd6;

    // Reset values and fixed-point constants
    localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 9'd256;
    localparam logic [DEG_W-1:0]   DEG_MIN_RST   = 8'd0;
    localparam logic [DEG_W-1:0]   DEG_MAX_RST   = 8'd180;
    localparam logic [STEP_W-1:0]  STEP_RST      = 6'd1;
    localparam logic [DEG_W-1:0]   DEG_SAT_MAX   = 8'd255;

    // Scaling: product of a reading and a degree span, and the reciprocal shift
    localparam int PROD_W      = AXIS_W + DEG_W;
    localparam int RECIP_SHIFT = PROD_W;

    localparam int DEFAULT_INPUT_SPAN = 1024;

    typedef struct packed {
        logic [AXIS_W-1:0] left_x;
        logic [AXIS_W-1:0] left_y;
        logic [AXIS_W-1:0] right_x;
        logic [AXIS_W-1:0] right_y;
        logic              left_button;
        logic              right_button;
    } t_sample;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha_left_x;
        logic [ALPHA_W-1:0] alpha_left_y;
        logic [ALPHA_W-1:0] alpha_right_x;
        logic [ALPHA_W-1:0] alpha_right_y;
        logic [DEG_W-1:0]   degree_min;
        logic [DEG_W-1:0]   degree_max;
        logic [STEP_W-1:0]  step_size;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic issuing;
    } t_back_status;

endpackage

>>> hdl/jss_front.sv
module jss_front import jss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_sample i_sample,
    output t_sample o_head,
    output logic    o_head_valid,
    input  logic    i_pop
);

    // Two-entry intake queue
    t_sample    r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;

    assign o_ready      = (r_count != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_head       = r_q[r_rptr];
    assign o_head_valid = (r_count != 2'd0);

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= i_sample;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/jss_back.sv
module jss_back import jss_pkg::*; #(
    parameter int INPUT_SPAN = DEFAULT_INPUT_SPAN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_sample          i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [DEG_W-1:0] o_servo_one_deg,
    output logic [DEG_W-1:0] o_servo_two_deg,
    output logic [DEG_W-1:0] o_servo_three_deg,
    output logic [DEG_W-1:0] o_servo_four_deg,
    output logic [DEG_W-1:0] o_servo_five_deg,
    output t_back_status     o_status
);

    // Division by the span: reciprocal multiply, then one correction step
    localparam int SPAN_W  = $clog2(INPUT_SPAN + 1);
    localparam int RECIP   = (1 << RECIP_SHIFT) / INPUT_SPAN;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int T_W     = PROD_W + RECIP_W;
    localparam int Q_MAX   = ((1 << AXIS_W) - 1) * 255 / INPUT_SPAN + 1;
    localparam int QW      = $clog2(Q_MAX + 1);
    localparam int QD_W    = QW + SPAN_W;
    localparam int CW      = (QD_W > PROD_W) ? QD_W : PROD_W;
    localparam int M_W     = ((QW > DEG_W) ? QW : DEG_W) + 2;
    localparam int SA_W    = SMOOTH_W + ALPHA_W;
    localparam int MA_W    = DEG_W + ALPHA_W;
    localparam int ACC_W   = SA_W + 1;

    // Sequencer
    logic                  r_busy;
    logic                  r_issue;
    logic [AXIS_IDX_W-1:0] r_axis;
    t_sample               r_cur;
    logic                  start;
    logic                  done;

    // Per-axis state
    logic [SMOOTH_W-1:0] r_smooth [AXIS_COUNT];
    logic [DEG_W-1:0]    r_held   [AXIS_COUNT];
    logic [DEG_W-1:0]    r_step_pos;
    logic [DEG_W-1:0]    n_step_pos;
    logic                r_out_valid;

    // Issue-stage selection
    logic [AXIS_W-1:0]       sel_v;
    logic [DEG_W-1:0]        sel_from;
    logic [DEG_W-1:0]        sel_to;
    logic [ALPHA_W-1:0]      sel_alpha;
    logic signed [DEG_W:0]   sel_diff;
    logic [DEG_W-1:0]        sel_mag;

    // Pipeline registers
    logic                  r_vld1, r_vld2, r_vld3, r_vld4, r_vld5, r_vld6;
    logic [AXIS_IDX_W-1:0] r_idx1, r_idx2, r_idx3, r_idx4, r_idx5, r_idx6;
    logic                  r_neg1, r_neg2, r_neg3, r_neg4;
    logic [DEG_W-1:0]      r_from1, r_from2, r_from3, r_from4;
    logic [ALPHA_W-1:0]    r_a1, r_a2, r_a3, r_a4, r_a5;
    logic [PROD_W-1:0]     r_p1, r_p2, r_p3;
    logic [T_W-1:0]        r_t2;
    logic [QW-1:0]         r_qe3;
    logic [QD_W-1:0]       r_qd3;
    logic [QW-1:0]         r_q4;
    logic [DEG_W-1:0]      r_m5;
    logic [SA_W-1:0]       r_sa6;
    logic [MA_W-1:0]       r_ma6;

    logic [QW-1:0]           qe;
    logic [CW-1:0]           rem;
    logic                    corr;
    logic signed [M_W-1:0]   m_full;
    logic [DEG_W-1:0]        m_sat;
    logic [ACC_W-1:0]        acc;
    logic [SMOOTH_W-1:0]     s_new;
    logic [DEG_W-1:0]        whole;
    logic signed [DEG_W+2:0] pos;

    // Start a new sample once the previous one is done and its result has left
    assign start = i_head_valid && !r_busy && (!r_out_valid || i_out_ready);
    assign o_pop = start;
    assign done  = r_vld6 && (r_idx6 == AXIS_LEFT_X);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_issue     <= 1'b0;
            r_axis      <= AXIS_LEFT_Y;
            r_out_valid <= 1'b0;
        end else begin
            if (start) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
                r_axis  <= AXIS_LEFT_Y;
            end else if (r_issue) begin
                r_axis <= r_axis + 1'b1;
                if (r_axis == AXIS_LEFT_X) begin
                    r_issue <= 1'b0;
                end
            end
            if (done) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cur <= i_head;
        end
    end

    // Axis selection; left x runs inverted from max down to min
    always_comb begin
        sel_v     = r_cur.left_y;
        sel_from  = i_cfg.degree_min;
        sel_to    = i_cfg.degree_max;
        sel_alpha = i_cfg.alpha_left_y;
        case (r_axis)
            AXIS_LEFT_Y: begin
                sel_v     = r_cur.left_y;
                sel_alpha = i_cfg.alpha_left_y;
            end
            AXIS_RIGHT_X: begin
                sel_v     = r_cur.right_x;
                sel_alpha = i_cfg.alpha_right_x;
            end
            AXIS_RIGHT_Y: begin
                sel_v     = r_cur.right_y;
                sel_alpha = i_cfg.alpha_right_y;
            end
            AXIS_LEFT_X: begin
                sel_v     = r_cur.left_x;
                sel_from  = i_cfg.degree_max;
                sel_to    = i_cfg.degree_min;
                sel_alpha = i_cfg.alpha_left_x;
            end
            default: begin
                sel_v     = r_cur.left_y;
                sel_alpha = i_cfg.alpha_left_y;
            end
        endcase
        sel_diff = $signed({1'b0, sel_to}) - $signed({1'b0, sel_from});
        sel_mag  = sel_diff[DEG_W] ? DEG_W'(-sel_diff) : sel_diff[DEG_W-1:0];
    end

    // Valid bits of the axis pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else begin
            r_vld1 <= r_issue;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
        end
    end

    // Division correction and offset/saturation
    assign qe     = r_t2[RECIP_SHIFT +: QW];
    assign rem    = CW'(r_p3) - CW'(r_qd3);
    assign corr   = (rem >= CW'(INPUT_SPAN));
    assign m_full = r_neg4 ? ($signed(M_W'(r_from4)) - $signed(M_W'(r_q4)))
                           : ($signed(M_W'(r_from4)) + $signed(M_W'(r_q4)));
    always_comb begin
        if (m_full < 0) begin
            m_sat = '0;
        end else if (m_full > $signed(M_W'(DEG_SAT_MAX))) begin
            m_sat = DEG_SAT_MAX;
        end else begin
            m_sat = m_full[DEG_W-1:0];
        end
    end

    // Axis datapath
    always_ff @(posedge i_clk) begin
        // stage 1: reading times degree span
        r_idx1  <= r_axis;
        r_neg1  <= sel_diff[DEG_W];
        r_from1 <= sel_from;
        r_a1    <= (sel_alpha > ALPHA_ONE) ? ALPHA_ONE : sel_alpha;
        r_p1    <= PROD_W'(sel_v) * PROD_W'(sel_mag);
        // stage 2: times reciprocal of the span
        r_idx2  <= r_idx1;
        r_neg2  <= r_neg1;
        r_from2 <= r_from1;
        r_a2    <= r_a1;
        r_p2    <= r_p1;
        r_t2    <= T_W'(r_p1) * T_W'(RECIP);
        // stage 3: back-multiply the estimate
        r_idx3  <= r_idx2;
        r_neg3  <= r_neg2;
        r_from3 <= r_from2;
        r_a3    <= r_a2;
        r_p3    <= r_p2;
        r_qe3   <= qe;
        r_qd3   <= QD_W'(qe) * QD_W'(INPUT_SPAN);
        // stage 4: estimate is low by at most one
        r_idx4  <= r_idx3;
        r_neg4  <= r_neg3;
        r_from4 <= r_from3;
        r_a4    <= r_a3;
        r_q4    <= r_qe3 + QW'(corr);
        // stage 5: add offset, saturate to a byte
        r_idx5  <= r_idx4;
        r_a5    <= r_a4;
        r_m5    <= m_sat;
        // stage 6: smoother products
        r_idx6  <= r_idx5;
        r_sa6   <= SA_W'(r_smooth[r_idx5]) * SA_W'(ALPHA_ONE - r_a5);
        r_ma6   <= MA_W'(r_m5) * MA_W'(r_a5);
    end

    // Smoother sum, integer part
    assign acc   = ACC_W'(r_sa6) + ACC_W'({r_ma6, 8'b0});
    assign s_new = acc[8 +: SMOOTH_W];
    assign whole = s_new[SMOOTH_W-1 -: DEG_W];

    // Smoothed state and held commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXIS_COUNT; k++) begin
                r_smooth[k] <= '0;
                r_held[k]   <= '0;
            end
        end else if (r_vld6) begin
            r_smooth[r_idx6] <= s_new;
            if ((whole > i_cfg.degree_min) && (whole < i_cfg.degree_max)) begin
                r_held[r_idx6] <= whole;
            end
        end
    end

    // Servo five: up step first, then down test on the raised value
    always_comb begin
        pos = $signed({3'b0, r_step_pos});
        if (i_head.left_button && (pos < $signed({3'b0, i_cfg.degree_max}))) begin
            pos = pos + $signed({5'b0, i_cfg.step_size});
        end
        if (i_head.right_button && (pos > $signed({3'b0, i_cfg.degree_min}))) begin
            pos = pos - $signed({5'b0, i_cfg.step_size});
        end
        if (pos < 0) begin
            n_step_pos = '0;
        end else if (pos > $signed({3'b0, DEG_SAT_MAX})) begin
            n_step_pos = DEG_SAT_MAX;
        end else begin
            n_step_pos = pos[DEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_pos <= '0;
        end else if (start) begin
            r_step_pos <= n_step_pos;
        end
    end

    // Result is the held state itself; it does not change while waiting
    assign o_out_valid       = r_out_valid;
    assign o_servo_one_deg   = r_held[AXIS_LEFT_Y];
    assign o_servo_two_deg   = r_held[AXIS_RIGHT_X];
    assign o_servo_three_deg = r_held[AXIS_RIGHT_Y];
    assign o_servo_four_deg  = r_held[AXIS_LEFT_X];
    assign o_servo_five_deg  = r_step_pos;

    assign o_status.busy    = r_busy;
    assign o_status.issuing = r_issue;

endmodule

>>> hdl/joystick_servo_smoother.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------
// sample   | i_valid / o_ready   | i_left_x/y, i_right_x/y, i_left/right_button
// command  | o_valid / i_ready   | o_servo_one..five_deg
// config   | i_cfg_we            | i_cfg_index, i_cfg_data
//
// After its sample leaves the intake queue, a result becomes valid once the four
// axes have been issued in turn and the last axis has passed through the axis
// pipeline and the state write.
// Samples are worked one at a time; the next starts only once the previous is done.
// The intake queue holds two samples, so up to two more are accepted while a
// result waits; after that o_ready drops until the back end pops one.
// A new sample starts once the previous result is taken (at the earliest in the
// same cycle); i_ready low stalls the back end while the queue keeps accepting.
// Reset is synchronous; all filter state, held commands and servo five clear.
module joystick_servo_smoother import jss_pkg::*; #(
    parameter int INPUT_SPAN = DEFAULT_INPUT_SPAN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [AXIS_W-1:0]     i_left_x,
    input  logic [AXIS_W-1:0]     i_left_y,
    input  logic [AXIS_W-1:0]     i_right_x,
    input  logic [AXIS_W-1:0]     i_right_y,
    input  logic                  i_left_button,
    input  logic                  i_right_button,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DEG_W-1:0]      o_servo_one_deg,
    output logic [DEG_W-1:0]      o_servo_two_deg,
    output logic [DEG_W-1:0]      o_servo_three_deg,
    output logic [DEG_W-1:0]      o_servo_four_deg,
    output logic [DEG_W-1:0]      o_servo_five_deg,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg         r_cfg;
    t_sample      in_sample;
    t_sample      head;
    logic         head_valid;
    logic         pop;
    t_back_status back_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha_left_x  <= ALPHA_ONE;
            r_cfg.alpha_left_y  <= ALPHA_ONE;
            r_cfg.alpha_right_x <= ALPHA_ONE;
            r_cfg.alpha_right_y <= ALPHA_ONE;
            r_cfg.degree_min    <= DEG_MIN_RST;
            r_cfg.degree_max    <= DEG_MAX_RST;
            r_cfg.step_size     <= STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA_LEFT_X:  r_cfg.alpha_left_x  <= i_cfg_data;
                CFG_ALPHA_LEFT_Y:  r_cfg.alpha_left_y  <= i_cfg_data;
                CFG_ALPHA_RIGHT_X: r_cfg.alpha_right_x <= i_cfg_data;
                CFG_ALPHA_RIGHT_Y: r_cfg.alpha_right_y <= i_cfg_data;
                CFG_DEGREE_MIN:    r_cfg.degree_min    <= i_cfg_data[DEG_W-1:0];
                CFG_DEGREE_MAX:    r_cfg.degree_max    <= i_cfg_data[DEG_W-1:0];
                CFG_STEP_SIZE:     r_cfg.step_size     <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_sample.left_x       = i_left_x;
    assign in_sample.left_y       = i_left_y;
    assign in_sample.right_x      = i_right_x;
    assign in_sample.right_y      = i_right_y;
    assign in_sample.left_button  = i_left_button;
    assign in_sample.right_button = i_right_button;

    // Intake queue
    jss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (in_sample),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    // Scaling, smoothing and servo update
    jss_back #(
        .INPUT_SPAN (INPUT_SPAN)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_head            (head),
        .i_head_valid      (head_valid),
        .o_pop             (pop),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_servo_one_deg   (o_servo_one_deg),
        .o_servo_two_deg   (o_servo_two_deg),
        .o_servo_three_deg (o_servo_three_deg),
        .o_servo_four_deg  (o_servo_four_deg),
        .o_servo_five_deg  (o_servo_five_deg),
        .o_status          (back_status)
    );

`ifndef SYNTHESIS
    // A waiting result and a sample in flight never overlap
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !back_status.busy)
        else $error("result valid while a sample is in flight");

    // A result appears only as the sample in flight completes
    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(back_status.busy))
        else $error("result appeared without a sample in flight");

    // Finishing a sample always raises a result
    a_busy_ends_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(back_status.busy) |-> $rose(o_valid))
        else $error("sample finished without a result");

    // Axis issue happens only while a sample is in flight
    a_issue_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.issuing |-> back_status.busy)
        else $error("axis issue outside a sample");
`endif

endmodule
